### sv/gbcl_pkg.sv
// Shared types and constants for the gyro bias calibration and glitch limiter.
package gbcl_pkg;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned LIMIT_W   = 14;
  localparam int unsigned CAL_SHIFT = 9;
  localparam int unsigned COUNT_W   = CAL_SHIFT + 1;
  localparam int unsigned CAL_COUNT = 1 << CAL_SHIFT;
  localparam int unsigned SAMPLE_W  = RAW_W - 1;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned BIAS_W    = SUM_W - CAL_SHIFT;
  localparam int unsigned WIDE_W    = RATE_W + 2;
  localparam int unsigned NUM_AXES  = 3;

  localparam logic [LIMIT_W-1:0] GLITCH_RESET = LIMIT_W'(800);

  typedef logic [LIMIT_W-1:0] limit_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    start_calibration;
  } in_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_roll;
    logic signed [RATE_W-1:0] rate_pitch;
    logic signed [RATE_W-1:0] rate_yaw;
    logic                     calibrating;
  } out_t;

endpackage

### sv/gyro_bias_calibrate_and_limit_core.sv
// Gyro bias calibration and glitch limiter: input register, one-pass datapath, result register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   in       | in_valid / in_ready    | in_data  (gbcl_pkg::in_t)
//   out      | out_valid / out_ready  | out_data (gbcl_pkg::out_t)
//   cfg      | cfg_valid / cfg_ready  | cfg_data (glitch limit)
//
// One request per cycle unless the result stalls; each result is held in the result register.
// The add, bias shift, subtract and clamp per axis sit between the input and result registers.
// Reset clears the counter, biases and previous rates, and sets the glitch limit to 800.
// A stalled result holds the input register; a new request is taken whenever the input
// register is empty or moves on in the same cycle. cfg_ready is always high.
module gyro_bias_calibrate_and_limit_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gbcl_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gbcl_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  gbcl_pkg::limit_t cfg_data
);

  gbcl_pkg::limit_t                       glitch_limit;
  logic [gbcl_pkg::COUNT_W-1:0]           calibration_count;
  logic [gbcl_pkg::COUNT_W-1:0]           calibration_count_next;
  logic [gbcl_pkg::COUNT_W-1:0]           count_eff;
  logic signed [gbcl_pkg::SUM_W-1:0]      bias_sum [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::SUM_W-1:0]      bias_sum_next [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::BIAS_W-1:0]     axis_bias [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::BIAS_W-1:0]     axis_bias_next [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::RATE_W-1:0]     previous_rate [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::RATE_W-1:0]     previous_rate_next [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::RAW_W-1:0]      raw [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::SAMPLE_W-1:0]   sample [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::RATE_W-1:0]     diff [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::WIDE_W-1:0]     diff_w [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::WIDE_W-1:0]     lo [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::WIDE_W-1:0]     hi [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::WIDE_W-1:0]     prev_w [gbcl_pkg::NUM_AXES];
  logic signed [gbcl_pkg::WIDE_W-1:0]     limit_w;
  logic signed [gbcl_pkg::BIAS_W-1:0]     bias_use [gbcl_pkg::NUM_AXES];

  gbcl_pkg::in_t  in_reg;
  logic           in_reg_valid;
  logic           advance;
  logic           cal;
  logic           first;

  assign advance   = in_reg_valid && (!out_valid || out_ready);
  assign in_ready  = !in_reg_valid || advance;
  assign cfg_ready = 1'b1;

  assign raw[0] = in_reg.raw_x;
  assign raw[1] = in_reg.raw_y;
  assign raw[2] = in_reg.raw_z;

  assign count_eff = in_reg.start_calibration ? gbcl_pkg::COUNT_W'(gbcl_pkg::CAL_COUNT)
                                              : calibration_count;
  assign cal       = count_eff != '0;
  assign first     = count_eff == gbcl_pkg::COUNT_W'(gbcl_pkg::CAL_COUNT);
  assign calibration_count_next = cal ? count_eff - 1'b1 : count_eff;
  assign limit_w   = $signed({{(gbcl_pkg::WIDE_W - gbcl_pkg::LIMIT_W){1'b0}}, glitch_limit});

  always_comb begin
    for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
      // negate the floor-by-four sample
      sample[a] = -($signed(gbcl_pkg::SAMPLE_W'(raw[a] >>> 2)));
      bias_sum_next[a] = (first ? '0 : bias_sum[a])
                       + gbcl_pkg::SUM_W'(sample[a]);
      axis_bias_next[a] = bias_sum_next[a][gbcl_pkg::SUM_W-1:gbcl_pkg::CAL_SHIFT];
      bias_use[a] = cal ? axis_bias_next[a] : axis_bias[a];
      diff[a] = gbcl_pkg::RATE_W'(sample[a]) - gbcl_pkg::RATE_W'(bias_use[a]);
      diff_w[a] = gbcl_pkg::WIDE_W'(diff[a]);
      prev_w[a] = gbcl_pkg::WIDE_W'(previous_rate[a]);
      lo[a] = prev_w[a] - limit_w;
      hi[a] = prev_w[a] + limit_w;
      priority if (diff_w[a] < lo[a]) begin
        previous_rate_next[a] = lo[a][gbcl_pkg::RATE_W-1:0];
      end else if (diff_w[a] > hi[a]) begin
        previous_rate_next[a] = hi[a][gbcl_pkg::RATE_W-1:0];
      end else begin
        previous_rate_next[a] = diff[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit <= gbcl_pkg::GLITCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      glitch_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_count <= '0;
      out_valid         <= 1'b0;
      for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
        axis_bias[a]     <= '0;
        previous_rate[a] <= '0;
      end
    end else begin
      if (advance) begin
        calibration_count <= calibration_count_next;
        out_valid         <= 1'b1;
        for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
          previous_rate[a] <= previous_rate_next[a];
          if (cal) begin
            axis_bias[a] <= axis_bias_next[a];
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sums carry no reset: the first sample of a run overwrites them
  always_ff @(posedge clk) begin
    if (advance && cal) begin
      for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
        bias_sum[a] <= bias_sum_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.rate_roll   <= previous_rate_next[0];
      out_data.rate_pitch  <= previous_rate_next[1];
      out_data.rate_yaw    <= previous_rate_next[2];
      out_data.calibrating <= cal;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    calibration_count <= gbcl_pkg::COUNT_W'(gbcl_pkg::CAL_COUNT))
    else $error("calibration counter above run length");

  a_out_tracks_prev: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_data.rate_roll == previous_rate[0] &&
                out_data.rate_pitch == previous_rate[1] &&
                out_data.rate_yaw == previous_rate[2])
    else $error("result differs from stored previous rate");

  a_start_flags_cal: assert property (@(posedge clk) disable iff (rst)
    advance && in_reg.start_calibration |=> out_valid && out_data.calibrating)
    else $error("start request not marked as calibrating");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && cal |=> calibration_count == $past(count_eff) - 1'b1)
    else $error("calibration counter did not step down");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_reg_valid |-> in_ready)
    else $error("input stalled with empty input register");

endmodule

### tb/sv/gyro_bias_calibrate_and_limit_core_tb.sv
// Self-checking testbench for the gyro bias calibration and glitch limiter core.
module gyro_bias_calibrate_and_limit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  gbcl_pkg::in_t    in_data   = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  gbcl_pkg::limit_t cfg_data  = '0;
  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  gbcl_pkg::out_t   out_data;

  gbcl_pkg::limit_t model_limit = gbcl_pkg::GLITCH_RESET;
  int     cal_left = 0;
  int     bias_acc [gbcl_pkg::NUM_AXES] = '{default: 0};
  int     axis_bias [gbcl_pkg::NUM_AXES] = '{default: 0};
  int     prev_rate [gbcl_pkg::NUM_AXES] = '{default: 0};
  int     centre [gbcl_pkg::NUM_AXES] = '{default: 0};

  gbcl_pkg::in_t  pending [$];
  gbcl_pkg::out_t rates_due [$];
  gbcl_pkg::out_t rate_want;
  bit             calm = 1'b0;
  bit             failed = 1'b0;
  int unsigned    cycles = 0;

  gyro_bias_calibrate_and_limit_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic gbcl_pkg::out_t predict_rates(gbcl_pkg::in_t s);
    int             raw [gbcl_pkg::NUM_AXES];
    int             g [gbcl_pkg::NUM_AXES];
    int             d;
    int             lo;
    int             hi;
    bit             cal;
    gbcl_pkg::out_t r;
    raw[0] = $signed(s.raw_x);
    raw[1] = $signed(s.raw_y);
    raw[2] = $signed(s.raw_z);
    for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) g[a] = -(raw[a] >>> 2);
    if (s.start_calibration) cal_left = gbcl_pkg::CAL_COUNT;
    cal = cal_left > 0;
    if (cal) begin
      for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
        if (cal_left == gbcl_pkg::CAL_COUNT) bias_acc[a] = 0;
        bias_acc[a] += g[a];
        axis_bias[a] = bias_acc[a] >>> gbcl_pkg::CAL_SHIFT;
      end
      cal_left--;
    end
    for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
      d  = g[a] - axis_bias[a];
      lo = prev_rate[a] - int'(model_limit);
      hi = prev_rate[a] + int'(model_limit);
      if (d < lo) d = lo;
      else if (d > hi) d = hi;
      prev_rate[a] = d;
    end
    r.rate_roll   = gbcl_pkg::RATE_W'(prev_rate[0]);
    r.rate_pitch  = gbcl_pkg::RATE_W'(prev_rate[1]);
    r.rate_yaw    = gbcl_pkg::RATE_W'(prev_rate[2]);
    r.calibrating = cal;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rates_due.push_back(predict_rates(in_data));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
          in_valid <= 1'b1;
          in_data  <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rates_due.size() == 0) begin
          $error("result with no request pending");
          failed = 1'b1;
        end else begin
          rate_want = rates_due.pop_front();
          check_field("rate_roll", rate_want.rate_roll, out_data.rate_roll);
          check_field("rate_pitch", rate_want.rate_pitch, out_data.rate_pitch);
          check_field("rate_yaw", rate_want.rate_yaw, out_data.rate_yaw);
          check_field("calibrating", rate_want.calibrating, out_data.calibrating);
        end
      end
      out_ready <= calm || $urandom_range(99) >= 6;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_sample(int x, int y, int z, bit kick);
    gbcl_pkg::in_t s;
    s.raw_x             = gbcl_pkg::RAW_W'(x);
    s.raw_y             = gbcl_pkg::RAW_W'(y);
    s.raw_z             = gbcl_pkg::RAW_W'(z);
    s.start_calibration = kick;
    pending.push_back(s);
  endtask

  function automatic logic [gbcl_pkg::RAW_W-1:0] pick_raw(int a);
    int v;
    if ($urandom_range(3) == 0) return gbcl_pkg::RAW_W'($urandom);
    v = centre[a] + int'($urandom_range(2000)) - 1000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return gbcl_pkg::RAW_W'(v);
  endfunction

  task automatic random_phase(int count, bit kick);
    gbcl_pkg::in_t s;
    for (int a = 0; a < gbcl_pkg::NUM_AXES; a++) begin
      centre[a] = $signed(gbcl_pkg::RAW_W'($urandom));
    end
    for (int i = 0; i < count; i++) begin
      s.raw_x             = pick_raw(0);
      s.raw_y             = pick_raw(1);
      s.raw_z             = pick_raw(2);
      s.start_calibration = (kick && i == 0) || $urandom_range(399) == 0;
      pending.push_back(s);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || rates_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_glitch_limit(gbcl_pkg::limit_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    model_limit = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    gbcl_pkg::limit_t mid;
    push_sample(0, 0, 0, 1'b0);
    push_sample(32767, -32768, -1, 1'b0);
    push_sample(32767, -32768, -1, 1'b0);
    push_sample(32767, -32768, -1, 1'b0);
    push_sample(-32768, 32767, 1, 1'b0);
    push_sample(1, 2, 3, 1'b0);
    push_sample(-4, 4, -5, 1'b0);
    push_sample(-32768, -32768, -32768, 1'b0);
    push_sample(32767, 32767, 32767, 1'b0);
    push_sample(400, -400, 1000, 1'b1);
    push_sample(404, -396, 1003, 1'b0);
    push_sample(-32768, 32767, 0, 1'b0);
    push_sample(399, -401, 998, 1'b0);
    push_sample(400, -400, 1000, 1'b0);
    push_sample(-1200, 2000, -7, 1'b1);
    push_sample(-1190, 2010, -3, 1'b0);
    push_sample(32767, -32768, 5, 1'b0);
    push_sample(-1200, 2000, -7, 1'b0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    write_glitch_limit('0);
    push_sample(32767, -32768, -1, 1'b0);
    push_sample(-32768, 32767, 1, 1'b1);
    push_sample(0, 0, 0, 1'b0);
    push_sample(12345, -23456, 7, 1'b0);
    wait_idle();

    write_glitch_limit(gbcl_pkg::limit_t'(16383));
    random_phase(600, 1'b1);
    wait_idle();

    write_glitch_limit(gbcl_pkg::limit_t'(1));
    random_phase(200, 1'b0);
    wait_idle();

    mid = gbcl_pkg::limit_t'($urandom_range(16382, 2));
    write_glitch_limit(mid);
    calm = 1'b1;
    random_phase(400, 1'b1);
    wait_idle();
    calm = 1'b0;

    write_glitch_limit(gbcl_pkg::limit_t'(16383));
    random_phase(200, 1'b0);
    wait_idle();
    random_phase(200, 1'b1);
    wait_idle();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
